// ===== rtl/shared_buffer_multi_queue_core_macros.svh =====
// ============================================================================
// Shared buffer multi-queue assertion macros
// Concurrent assertion shorthands used by the block's port checker.
// ============================================================================
`ifndef SHARED_BUFFER_MULTI_QUEUE_CORE_MACROS_SVH
`define SHARED_BUFFER_MULTI_QUEUE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBMQ_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbmq assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SBMQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbmq assertion failed");

// The consequent must hold at a later cycle than the antecedent.
`define SBMQ_ASSERT_TWO(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error("sbmq assertion failed");

`endif

// ===== rtl/sbmq_pkg.sv =====
// ============================================================================
// Shared buffer multi-queue package
// Sizes, pointer types and operation and status codes of the block.
// ============================================================================
`default_nettype none

package sbmq_pkg;

    localparam int ENTRIES   = 16;
    localparam int QUEUES    = 4;
    localparam int DATA_BITS = 32;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int PTR_W = $clog2(ENTRIES + 1);
    localparam int QID_W = (QUEUES > 1) ? $clog2(QUEUES) : 1;

    typedef logic [PTR_W-1:0]     ptr_t;
    typedef logic [1:0]           op_t;
    typedef logic [1:0]           status_t;
    typedef logic [DATA_BITS-1:0] data_t;

    // A pointer equal to the entry count is the null pointer.
    localparam ptr_t NIL_PTR = PTR_W'(ENTRIES);

    localparam op_t OP_ENQ      = 2'd0;
    localparam op_t OP_DEQ      = 2'd1;
    localparam op_t OP_PEEK     = 2'd2;
    localparam op_t OP_RESERVED = 2'd3;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/sbmq_ram.sv =====
// ============================================================================
// Generic single-port-pair RAM
// One write port and one read port with a registered read data output.
// ============================================================================
`default_nettype none

module sbmq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/shared_buffer_multi_queue_core.sv =====
// ============================================================================
// Shared buffer multi-queue core
// Several FIFO queues kept as linked lists in one shared entry store.
// ============================================================================
// The block takes one operation (enqueue, dequeue or peek) per cycle while
// item_stall is low and returns exactly one result per operation, in order.
// An accepted transaction sits in the input register, then in the result
// register: the head, tail and free-list pointers are walked from the input
// register, and the entry RAM is written or read at the same edge that loads
// the result register, so the RAM's registered read lines up with the result
// status. While a result waits on result_stall, one more operation is taken
// into the input register; after that item_stall rises. An enqueue with no
// free entry reports status full, and a dequeue or peek on an empty or
// nonexistent queue reports status empty, both with result data zero.
`default_nettype none

module shared_buffer_multi_queue_core (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   item_valid,
    output logic                        item_stall,
    input  wire logic [1:0]             operation,
    input  wire logic [1:0]             queue_id,
    input  wire logic signed [31:0]     entry_data,
    output logic                        result_valid,
    input  wire logic                   result_stall,
    output logic signed [31:0]          result_data,
    output sbmq_pkg::status_t           status
);

    import sbmq_pkg::*;

    // Input register
    logic        p_valid_reg;
    op_t         p_op_reg;
    logic [1:0]  p_qid_reg;
    data_t       p_data_reg;

    // Output register
    logic        o_valid_reg;
    status_t     o_status_reg;
    logic        o_rd_reg;

    // Queue state
    ptr_t link_reg [ENTRIES];
    ptr_t link_next [ENTRIES];
    ptr_t head_reg [QUEUES];
    ptr_t head_next [QUEUES];
    ptr_t tail_reg [QUEUES];
    ptr_t tail_next [QUEUES];
    ptr_t free_reg;
    ptr_t free_next;

    logic        p_adv;
    logic        p_go;
    logic        in_accept;
    logic [QID_W-1:0] q_idx;
    logic        q_ok;
    ptr_t        cur_head;
    ptr_t        cur_tail;
    logic        head_ok;
    logic        tail_ok;
    logic        free_ok;
    status_t     status_next;
    logic        rd_next;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    logic signed [DATA_BITS-1:0] ram_rdata;

    assign p_adv      = !o_valid_reg || !result_stall;
    assign p_go       = p_valid_reg && p_adv;
    assign item_stall = p_valid_reg && !p_adv;
    assign in_accept  = item_valid && !item_stall;

    assign q_idx    = QID_W'(p_qid_reg);
    assign q_ok     = (int'(p_qid_reg) < QUEUES);
    assign cur_head = head_reg[q_idx];
    assign cur_tail = tail_reg[q_idx];
    assign head_ok  = (cur_head < NIL_PTR);
    assign tail_ok  = (cur_tail < NIL_PTR);
    assign free_ok  = (free_reg < NIL_PTR);

    assign ram_waddr = free_reg[IDX_W-1:0];
    assign ram_raddr = cur_head[IDX_W-1:0];

    always_comb
    begin
        link_next   = link_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        free_next   = free_reg;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        status_next = ST_OK;
        rd_next     = 1'b0;
        unique case (p_op_reg)
            OP_ENQ:
            begin
                if (!q_ok)
                begin
                    status_next = ST_EMPTY;
                end
                else if (!free_ok)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    free_next = link_reg[free_reg[IDX_W-1:0]];
                    if (!head_ok)
                    begin
                        head_next[q_idx] = free_reg;
                    end
                    else if (tail_ok)
                    begin
                        link_next[cur_tail[IDX_W-1:0]] = free_reg;
                    end
                    // The new entry ends the list; this write wins over the tail link.
                    link_next[free_reg[IDX_W-1:0]] = NIL_PTR;
                    tail_next[q_idx] = free_reg;
                    ram_we = p_go;
                end
            end
            OP_DEQ, OP_PEEK:
            begin
                if (!q_ok || !head_ok)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    rd_next = 1'b1;
                    ram_re  = p_go;
                    if (p_op_reg == OP_DEQ)
                    begin
                        head_next[q_idx]                = link_reg[cur_head[IDX_W-1:0]];
                        link_next[cur_head[IDX_W-1:0]] = free_reg;
                        free_next                       = cur_head;
                    end
                end
            end
            default:
            begin
                // The reserved code changes nothing and reports ok.
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
            free_reg    <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                link_reg[i] <= PTR_W'(i + 1);
            end
            for (int i = 0; i < QUEUES; i++)
            begin
                head_reg[i] <= NIL_PTR;
                tail_reg[i] <= NIL_PTR;
            end
        end
        else
        begin
            if (in_accept)
            begin
                p_valid_reg <= 1'b1;
            end
            else if (p_go)
            begin
                p_valid_reg <= 1'b0;
            end
            if (p_adv)
            begin
                o_valid_reg <= p_valid_reg;
            end
            if (p_go)
            begin
                link_reg <= link_next;
                head_reg <= head_next;
                tail_reg <= tail_next;
                free_reg <= free_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            p_op_reg   <= operation;
            p_qid_reg  <= queue_id;
            p_data_reg <= DATA_BITS'(entry_data);
        end
        if (p_go)
        begin
            o_status_reg <= status_next;
            o_rd_reg     <= rd_next;
        end
    end

    sbmq_ram #(
        .WIDTH (DATA_BITS),
        .DEPTH (ENTRIES)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (p_data_reg),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign result_valid = o_valid_reg;
    assign status       = o_status_reg;
    assign result_data  = o_rd_reg ? 32'(ram_rdata) : '0;

endmodule

`default_nettype wire

// ===== rtl/sbmq_checker.sv =====
// ============================================================================
// Shared buffer multi-queue port checker
// Port-level assertions on handshake timing and result encoding.
// ============================================================================
`default_nettype none

`include "shared_buffer_multi_queue_core_macros.svh"

module sbmq_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    input  wire logic               item_stall,
    input  wire logic               result_valid,
    input  wire logic               result_stall,
    input  wire logic signed [31:0] result_data,
    input  wire sbmq_pkg::status_t  status
);

    import sbmq_pkg::*;

    // A stalled result transaction holds its payload.
    `SBMQ_ASSERT_NEXT(a_result_hold, result_valid && result_stall,
        result_valid && $stable(status) && $stable(result_data))

    // Full and empty reports never carry data.
    `SBMQ_ASSERT_SAME(a_error_zero,
        result_valid && (status == ST_FULL || status == ST_EMPTY), result_data == '0)

    // The input only backs up behind a stalled result.
    `SBMQ_ASSERT_SAME(a_stall_cause, item_stall, result_valid && result_stall)

    // An accepted transaction is followed by a valid result on the port.
    `SBMQ_ASSERT_TWO(a_latency, item_valid && !item_stall, result_valid)

endmodule

bind shared_buffer_multi_queue_core sbmq_checker u_sbmq_checker (.*);

`default_nettype wire
